FILE: hw/rtl/frame_deque_ring_top_macros.svh
// assertion macros shared by the frame deque ring rtl
`ifndef FRAME_DEQUE_RING_TOP_MACROS_SVH
`define FRAME_DEQUE_RING_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fdr check failed");
`define FDR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdr check failed");
`define FDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdr check failed");
`else
`define FDR_ASSERT(label, cond)
`define FDR_ASSERT_IMP(label, ante, cons)
`define FDR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/fdr_pkg.sv
// shared types and codes of the frame deque ring
package fdr_pkg;

  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd3;

  localparam logic [1:0] OPEN_IDLE   = 2'd0;
  localparam logic [1:0] OPEN_BACK   = 2'd1;
  localparam logic [1:0] OPEN_FRONT  = 2'd2;
  localparam logic [1:0] OPEN_REJECT = 2'd3;

  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_MAX   = 1'b1;

  localparam logic [CAP_W-1:0] SLOTS_RESET = 4'd8;
  localparam logic [LEN_W-1:0] MAX_RESET   = 7'd64;

  typedef struct packed {
    logic [CAP_W-1:0] slots_in_use;
    logic [LEN_W-1:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic wr_slots;
    logic wr_max;
  } cfg_evt_t;

  typedef struct packed {
    logic [LEN_W-1:0]  frame_length;
    logic [STAT_W-1:0] status;
    logic              last;
    logic              from_mem;
  } res_meta_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [LEN_W-1:0]  frame_length;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

FILE: hw/rtl/fdr_if.sv
// item and result channel interfaces of the frame deque ring
interface fdr_item_if import fdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              empty_frame;

  modport source (output valid, cmd, data_byte, last_byte, empty_frame, input ready);
  modport sink (input valid, cmd, data_byte, last_byte, empty_frame, output ready);
endinterface

interface fdr_result_if import fdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic [LEN_W-1:0]  frame_length;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, byte_out, frame_length, status, last, input ready);
  modport sink (input valid, byte_out, frame_length, status, last, output ready);
endinterface

FILE: hw/rtl/fdr_cfg.sv
// apb register block of the frame deque ring
module fdr_cfg import fdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output cfg_evt_t          evt
);

  logic reg_idx;
  logic wr;

  assign reg_idx = paddr[2];
  assign wr      = psel & penable & pwrite;
  assign pready  = 1'b1;

  assign evt.wr_slots = wr && (reg_idx == REG_SLOTS);
  assign evt.wr_max   = wr && (reg_idx == REG_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slots_in_use    <= SLOTS_RESET;
      cfg.max_frame_bytes <= MAX_RESET;
    end else begin
      if (evt.wr_slots) begin
        cfg.slots_in_use <= pwdata[CAP_W-1:0];
      end
      if (evt.wr_max) begin
        cfg.max_frame_bytes <= pwdata[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOTS: prdata = APB_DW'(cfg.slots_in_use);
      REG_MAX:   prdata = APB_DW'(cfg.max_frame_bytes);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/fdr_ctrl.sv
// frame and length memories with the push, pop and result sequencer
`include "frame_deque_ring_top_macros.svh"
module fdr_ctrl import fdr_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cfg_evt_t  evt,
  fdr_item_if.sink  items,
  fdr_result_if.source results
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DEPTH  = SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW2    = ADDR_W + LEN_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LEN    = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0] c);
    logic [CNT_W:0] nx;
    nx = {1'b0, CNT_W'(s)} + 1'b1;
    if (nx >= {1'b0, c}) slot_inc = '0;
    else slot_inc = SLOT_W'(nx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0] c);
    if (s == '0 || CNT_W'(s) >= c) slot_dec = SLOT_W'(c - 1'b1);
    else slot_dec = s - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0] i);
    logic [AW2-1:0] a;
    a = AW2'(s) * AW2'(SLOT_BYTES) + AW2'(i);
    byte_addr = a[ADDR_W-1:0];
  endfunction

  function automatic res_meta_t mk_meta(input logic [LEN_W-1:0] len,
                                        input logic [STAT_W-1:0] st,
                                        input logic l, input logic m);
    res_meta_t r;
    r.frame_length = len;
    r.status       = st;
    r.last         = l;
    r.from_mem     = m;
    mk_meta = r;
  endfunction

  // memories
  logic [BYTE_W-1:0] byte_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem [SLOTS];

  logic              byte_we, byte_re, len_we, len_re;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic [SLOT_W-1:0] len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata;
  logic [BYTE_W-1:0] rd_byte;
  logic [LEN_W-1:0]  rd_len;

  always_ff @(posedge clk) begin
    if (byte_we) byte_mem[byte_waddr] <= items.data_byte;
    if (byte_re) rd_byte <= byte_mem[byte_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (len_re) rd_len <= len_mem[len_raddr];
  end

  // state
  logic [1:0]        state, state_next;
  logic [SLOT_W-1:0] front_slot, front_next, back_slot, back_next;
  logic [CNT_W-1:0]  entry_count, count_next;
  logic [LEN_W-1:0]  fill_position, fill_next;
  logic [1:0]        push_open, open_next;
  logic [SLOT_W-1:0] push_slot, pslot_next;
  logic [SLOT_W-1:0] pop_slot, pop_slot_next;
  logic [LEN_W-1:0]  cur_len, cur_len_next, idx, idx_next;

  logic              s1_valid;
  res_meta_t         s1_meta;
  logic              issue;
  res_meta_t         issue_meta;

  result_t           fifo [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        occ;

  logic              in_fire, out_fire, can_issue;
  logic [CNT_W-1:0]  cap;
  logic [LEN_W-1:0]  mx;

  logic [1:0]        want, open_base;
  logic [LEN_W-1:0]  fill_base, fill_new, commit_len, stream_idx;
  logic [SLOT_W-1:0] slot_base, pop_sel;

  assign in_fire  = items.valid & items.ready;
  assign out_fire = results.valid & results.ready;
  assign can_issue = ((3'(occ) + 3'(s1_valid)) - 3'(out_fire)) < 3'd2;
  assign items.ready = (state == ST_IDLE) && can_issue;

  assign results.valid        = occ != 2'd0;
  assign results.byte_out     = fifo[rd_ptr].byte_out;
  assign results.frame_length = fifo[rd_ptr].frame_length;
  assign results.status       = fifo[rd_ptr].status;
  assign results.last         = fifo[rd_ptr].last;

  always_comb begin
    if (cfg.slots_in_use == '0) cap = CNT_W'(1);
    else if (32'(cfg.slots_in_use) > SLOTS) cap = CNT_W'(SLOTS);
    else cap = CNT_W'(cfg.slots_in_use);
  end

  always_comb begin
    if (cfg.max_frame_bytes == '0) mx = LEN_W'(1);
    else if (32'(cfg.max_frame_bytes) > SLOT_BYTES) mx = LEN_W'(SLOT_BYTES);
    else mx = cfg.max_frame_bytes;
  end

  always_comb begin
    state_next    = state;
    front_next    = front_slot;
    back_next     = back_slot;
    count_next    = entry_count;
    fill_next     = fill_position;
    open_next     = push_open;
    pslot_next    = push_slot;
    pop_slot_next = pop_slot;
    cur_len_next  = cur_len;
    idx_next      = idx;
    byte_we       = 1'b0;
    byte_waddr    = '0;
    byte_re       = 1'b0;
    byte_raddr    = '0;
    len_we        = 1'b0;
    len_waddr     = '0;
    len_wdata     = '0;
    len_re        = 1'b0;
    len_raddr     = '0;
    issue         = 1'b0;
    issue_meta    = '0;
    want          = (items.cmd == CMD_PUSH_BACK) ? OPEN_BACK : OPEN_FRONT;
    open_base     = push_open;
    fill_base     = fill_position;
    slot_base     = push_slot;
    fill_new      = fill_position;
    commit_len    = '0;
    pop_sel       = front_slot;
    stream_idx    = LEN_W'(idx + 1'b1);

    if (evt.wr_slots || evt.wr_max) begin
      open_next = OPEN_IDLE;
      fill_next = '0;
      if (evt.wr_slots) begin
        front_next = '0;
        back_next  = '0;
        count_next = '0;
      end
    end else if (in_fire) begin
      if (items.cmd == CMD_PUSH_BACK || items.cmd == CMD_PUSH_FRONT) begin
        // switching ends drops the open frame
        if (push_open != OPEN_IDLE && push_open != OPEN_REJECT && push_open != want) begin
          open_base = OPEN_IDLE;
        end
        if (open_base == OPEN_IDLE) begin
          fill_base = '0;
          if (entry_count >= cap) begin
            open_base = OPEN_REJECT;
          end else begin
            open_base = want;
            slot_base = (want == OPEN_BACK) ? back_slot : slot_dec(front_slot, cap);
          end
        end
        fill_new = fill_base;
        if (open_base != OPEN_REJECT && !items.empty_frame) begin
          if (fill_base < mx) begin
            byte_we    = 1'b1;
            byte_waddr = byte_addr(slot_base, fill_base);
            fill_new   = LEN_W'(fill_base + 1'b1);
          end else begin
            fill_new = LEN_W'(mx + 1'b1);
          end
        end
        if (items.last_byte || items.empty_frame) begin
          issue     = 1'b1;
          open_next = OPEN_IDLE;
          fill_next = '0;
          if (open_base == OPEN_REJECT) begin
            issue_meta = mk_meta('0, STAT_FULL, 1'b1, 1'b0);
          end else begin
            commit_len = (fill_new > mx) ? mx : fill_new;
            len_we     = 1'b1;
            len_waddr  = slot_base;
            len_wdata  = commit_len;
            if (open_base == OPEN_BACK) back_next = slot_inc(back_slot, cap);
            else front_next = slot_base;
            count_next = CNT_W'(entry_count + 1'b1);
            issue_meta = mk_meta(commit_len, (fill_new > mx) ? STAT_TRUNC : STAT_OK,
                                 1'b1, 1'b0);
          end
        end else begin
          open_next  = open_base;
          fill_next  = fill_new;
          pslot_next = slot_base;
        end
      end else begin
        open_next = OPEN_IDLE;
        fill_next = '0;
        unique case (items.cmd)
          CMD_CLEAR: begin
            front_next = '0;
            back_next  = '0;
            count_next = '0;
            issue      = 1'b1;
            issue_meta = mk_meta('0, STAT_OK, 1'b1, 1'b0);
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT: begin
            if (entry_count == '0) begin
              issue      = 1'b1;
              issue_meta = mk_meta('0, STAT_EMPTY, 1'b1, 1'b0);
            end else begin
              if (items.cmd == CMD_POP_BACK) begin
                pop_sel    = slot_dec(back_slot, cap);
                back_next  = pop_sel;
                count_next = entry_count - 1'b1;
              end else if (items.cmd == CMD_POP_FRONT) begin
                front_next = slot_inc(front_slot, cap);
                count_next = entry_count - 1'b1;
              end
              len_re        = 1'b1;
              len_raddr     = pop_sel;
              pop_slot_next = pop_sel;
              state_next    = ST_LEN;
            end
          end
          default: ;
        endcase
      end
    end else begin
      unique case (state)
        ST_LEN: begin
          if (can_issue) begin
            issue = 1'b1;
            if (rd_len == '0) begin
              issue_meta = mk_meta('0, STAT_OK, 1'b1, 1'b0);
              state_next = ST_IDLE;
            end else begin
              byte_re      = 1'b1;
              byte_raddr   = byte_addr(pop_slot, '0);
              issue_meta   = mk_meta(rd_len, STAT_OK, rd_len == LEN_W'(1), 1'b1);
              cur_len_next = rd_len;
              idx_next     = LEN_W'(1);
              state_next   = (rd_len == LEN_W'(1)) ? ST_IDLE : ST_STREAM;
            end
          end
        end
        ST_STREAM: begin
          if (can_issue) begin
            issue      = 1'b1;
            byte_re    = 1'b1;
            byte_raddr = byte_addr(pop_slot, idx);
            issue_meta = mk_meta(cur_len, STAT_OK, stream_idx == cur_len, 1'b1);
            idx_next   = stream_idx;
            if (stream_idx == cur_len) state_next = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      front_slot    <= '0;
      back_slot     <= '0;
      entry_count   <= '0;
      fill_position <= '0;
      push_open     <= OPEN_IDLE;
      push_slot     <= '0;
      s1_valid      <= 1'b0;
      occ           <= 2'd0;
      wr_ptr        <= 1'b0;
      rd_ptr        <= 1'b0;
    end else begin
      state         <= state_next;
      front_slot    <= front_next;
      back_slot     <= back_next;
      entry_count   <= count_next;
      fill_position <= fill_next;
      push_open     <= open_next;
      push_slot     <= pslot_next;
      s1_valid      <= issue;
      occ           <= 2'((3'(occ) + 3'(s1_valid)) - 3'(out_fire));
      if (s1_valid) wr_ptr <= ~wr_ptr;
      if (out_fire) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    pop_slot <= pop_slot_next;
    cur_len  <= cur_len_next;
    idx      <= idx_next;
    if (issue) s1_meta <= issue_meta;
    if (s1_valid) begin
      fifo[wr_ptr].byte_out     <= s1_meta.from_mem ? rd_byte : '0;
      fifo[wr_ptr].frame_length <= s1_meta.frame_length;
      fifo[wr_ptr].status       <= s1_meta.status;
      fifo[wr_ptr].last         <= s1_meta.last;
    end
  end

  `FDR_ASSERT(a_occ_bound, occ <= 2'd2)
  `FDR_ASSERT(a_count_cap, entry_count <= cap)
  `FDR_ASSERT_IMP(a_fill_idle, push_open == OPEN_IDLE, fill_position == '0)
  `FDR_ASSERT_NEXT(a_issue_lands, s1_valid, occ != 2'd0)
  `FDR_ASSERT_NEXT(a_pop_reads_len, in_fire && !evt.wr_slots && !evt.wr_max && entry_count != '0 && (items.cmd == CMD_POP_FRONT || items.cmd == CMD_POP_BACK || items.cmd == CMD_PEEK_FRONT), state == ST_LEN)

endmodule

FILE: hw/rtl/frame_deque_ring_top.sv
// top level of the frame deque ring
// Double-ended ring of SLOTS frame slots of SLOT_BYTES bytes each. A push takes
// one byte per cycle while no pop streams and the output buffer has room; its
// final beat returns one commit beat (ok, full or truncated). A pop or peek reads
// the slot length from the length memory, then one byte per cycle from the frame
// memory while the output buffer has room, both memories with registered reads;
// a zero-length frame, an empty ring and clear return a single beat, and unused
// commands return none. Results pass through a one-beat stage and a two-beat
// output buffer, so a stalled sink holds off new items once two beats are waiting.
// Writing slots_in_use empties the ring; either register write drops an open push.
module frame_deque_ring_top import fdr_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  fdr_item_if.sink          items,
  fdr_result_if.source      results
);

  cfg_t     cfg;
  cfg_evt_t evt;

  fdr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  fdr_ctrl #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .evt     (evt),
    .items   (items),
    .results (results)
  );

endmodule
